>>> hdl/hmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_pkg
// Shared types and constants of the histogram mode finder: the payload
// structs of both channels and the fixed field widths.
// ----------------------------------------------------------------------------

package hmf_pkg;

  // Fixed field widths of the channels.
  localparam int VAL_W   = 10;
  localparam int MCNT_W  = 8;

  // Width of the set tag kept next to each histogram count.
  localparam int EPOCH_W = 12;

  // One input transfer.
  typedef struct packed {
    logic [VAL_W-1:0] sample_value;
    logic             last_item;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic              repeat_found;
    logic [VAL_W-1:0]  mode_value;
    logic [MCNT_W-1:0] mode_count;
  } out_t;

endpackage

>>> hdl/hmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. A read of the address being written returns the old data.
// ----------------------------------------------------------------------------

module hmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/histogram_mode_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_mode_finder
// Counts sample values per set in a histogram RAM and reports the most
// frequent value and its count when the set ends.
//
// Usage:
//   The input channel (in_valid / in_ready / in_data) carries one sample per
//   transfer; last_item closes the set. The result channel (out_valid /
//   out_ready / out_data) carries one result per set, sent after its last
//   sample. The result is cleared when no value occurred more than once.
//   Throughput is one sample per cycle while in_ready is high: each sample
//   does one read-modify-write of its bin, the read issued at acceptance
//   and the write in the next cycle, with the just-written bin forwarded to
//   a following hit. A closing sample's result is registered into the
//   output queue, which drives out_valid. Each bin holds a set tag, so a new
//   set starts without clearing the RAM. After reset, and again every 4096
//   sets when the tag wraps, a clearing pass zeroes the RAM; in_ready is low
//   meanwhile. A two-entry output queue absorbs a stalled receiver; in_ready
//   also drops when a further result might not find room in it.
// ----------------------------------------------------------------------------

module histogram_mode_finder #(
  parameter int BINS      = 1024,
  parameter int MAX_ITEMS = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hmf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hmf_pkg::out_t out_data
);

  localparam int ADDR_W = $clog2(BINS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int WORD_W = hmf_pkg::EPOCH_W + CNT_W;

  typedef struct packed {
    logic [hmf_pkg::EPOCH_W-1:0] tag;
    logic [CNT_W-1:0]            cnt;
  } bin_word_t;

  // Sample in flight between read and write.
  typedef struct packed {
    logic [hmf_pkg::VAL_W-1:0] value;
    logic [ADDR_W-1:0]         addr;
    logic                      in_range;
    logic                      last;
  } stage_t;

  // Pipeline stage.
  logic   s1_vld_r, s1_vld_nxt;
  stage_t s1_r, s1_nxt;

  // Mode tracker and set tag.
  logic [CNT_W-1:0]            best_cnt_r, best_cnt_nxt;
  logic [hmf_pkg::VAL_W-1:0]   best_val_r, best_val_nxt;
  logic [hmf_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;

  // Clearing pass.
  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // Forwarding of the last bin write.
  logic              fwd_vld_r, fwd_vld_nxt;
  logic [ADDR_W-1:0] fwd_addr_r, fwd_addr_nxt;
  bin_word_t         fwd_word_r, fwd_word_nxt;

  // Output queue: q0 is the head.
  logic [1:0]    occ_r, occ_nxt;
  hmf_pkg::out_t q0_r, q0_nxt;
  hmf_pkg::out_t q1_r, q1_nxt;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  bin_word_t         ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // Datapath signals.
  logic              in_xfer;
  bin_word_t         cur_word;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  new_cnt;
  logic              take_best;
  logic [CNT_W-1:0]  fin_cnt;
  logic [hmf_pkg::VAL_W-1:0] fin_val;
  logic              push;
  logic              pop;
  hmf_pkg::out_t     push_data;
  logic [2:0]        rsv;

  hmf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BINS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ADDR_W'(in_data.sample_value)),
    .rdata (ram_rdata)
  );

  // Handshakes. A new sample is taken only if its result is sure to fit.
  assign pop       = out_valid && out_ready;
  assign push      = s1_vld_r && s1_r.last;
  assign rsv       = 3'(occ_r) + 3'(push);
  assign in_ready  = !clr_busy_r && (rsv < (3'd2 + 3'(pop)))
                     && !(push && (epoch_r == '1));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (occ_r != 2'd0);
  assign out_data  = q0_r;

  // Bin update: forward the previous write on a hit, drop stale tags.
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == s1_r.addr)) begin
      cur_word = fwd_word_r;
    end else begin
      cur_word = bin_word_t'(ram_rdata);
    end
    cur_cnt = (cur_word.tag == epoch_r) ? cur_word.cnt : '0;
    new_cnt = (cur_cnt < CNT_W'(MAX_ITEMS)) ? cur_cnt + CNT_W'(1) : cur_cnt;
    take_best = s1_vld_r && s1_r.in_range && (new_cnt > best_cnt_r);
    fin_cnt = take_best ? new_cnt : best_cnt_r;
    fin_val = take_best ? s1_r.value : best_val_r;
  end

  // Result of a closing sample.
  always_comb begin
    push_data = '0;
    if (fin_cnt > CNT_W'(1)) begin
      push_data.repeat_found = 1'b1;
      push_data.mode_value   = fin_val;
      push_data.mode_count   = hmf_pkg::MCNT_W'(fin_cnt);
    end
  end

  // RAM write port: clearing pass or bin write-back.
  always_comb begin
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_vld_r && s1_r.in_range;
      ram_waddr = s1_r.addr;
      ram_wdata = '{tag: epoch_r, cnt: new_cnt};
    end
  end

  // Next-state logic of the pipeline, tracker, clearing pass and forwarding.
  always_comb begin
    s1_vld_nxt = in_xfer;
    s1_nxt.value    = in_data.sample_value;
    s1_nxt.addr     = ADDR_W'(in_data.sample_value);
    s1_nxt.in_range = (int'(in_data.sample_value) < BINS);
    s1_nxt.last     = in_data.last_item;

    best_cnt_nxt = fin_cnt;
    best_val_nxt = fin_val;
    epoch_nxt    = epoch_r;
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (push) begin
      best_cnt_nxt = '0;
      best_val_nxt = '0;
      epoch_nxt    = epoch_r + hmf_pkg::EPOCH_W'(1);
      if (epoch_r == '1) begin
        clr_busy_nxt = 1'b1;
        clr_addr_nxt = '0;
      end
    end
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(BINS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    fwd_vld_nxt  = !clr_busy_r && s1_vld_r && s1_r.in_range;
    fwd_addr_nxt = s1_r.addr;
    fwd_word_nxt = ram_wdata;
  end

  // Output queue.
  always_comb begin
    occ_nxt = occ_r;
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    if (push && pop) begin
      if (occ_r == 2'd1) begin
        q0_nxt = push_data;
      end else begin
        q0_nxt = q1_r;
        q1_nxt = push_data;
      end
    end else if (pop) begin
      q0_nxt  = q1_r;
      occ_nxt = occ_r - 2'd1;
    end else if (push) begin
      if (occ_r == 2'd0) begin
        q0_nxt = push_data;
      end else begin
        q1_nxt = push_data;
      end
      occ_nxt = occ_r + 2'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      best_cnt_r <= '0;
      best_val_r <= '0;
      epoch_r    <= '0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      fwd_vld_r  <= 1'b0;
      occ_r      <= 2'd0;
    end else begin
      s1_vld_r   <= s1_vld_nxt;
      best_cnt_r <= best_cnt_nxt;
      best_val_r <= best_val_nxt;
      epoch_r    <= epoch_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      fwd_vld_r  <= fwd_vld_nxt;
      occ_r      <= occ_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    fwd_addr_r <= fwd_addr_nxt;
    fwd_word_r <= fwd_word_nxt;
    q0_r       <= q0_nxt;
    q1_r       <= q1_nxt;
  end

  // No sample is taken while the RAM is being cleared.
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("sample accepted during clearing pass");

  // The output queue never overflows.
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && (occ_r == 2'd2)))
    else $error("output queue overflow");

  // The stage holds a sample only in the cycle after a transfer.
  a_stage_source: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> $past(in_valid && in_ready))
    else $error("pipeline stage valid without input transfer");

  // A result without a repeat is fully cleared.
  a_cleared_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.repeat_found) |->
      ((out_data.mode_value == '0) && (out_data.mode_count == '0)))
    else $error("non-repeat result not cleared");

endmodule

>>> bench/histogram_mode_finder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_mode_finder_test
// Self-checking bench for the histogram mode finder. Sample sets are driven
// on the input channel, and a scoreboard object keeps its own histogram and
// best-value tracker to predict the result of each set. Every result transfer
// is compared with the oldest prediction. A directed opening covers the range
// ends, ties, sets without repeats and reuse of the histogram. Random sets
// follow: mostly repeat-heavy sets drawn from small value pools, some noise,
// and a few long sets that saturate a bin. The sender and the receiver idle
// at different rates from phase to phase.
// ----------------------------------------------------------------------------

module histogram_mode_finder_test;

  localparam int TB_BINS        = 1024;
  localparam int TB_MAX_ITEMS   = 128;
  localparam int RANDOM_SAMPLES = 1150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;

  // Predicts the result of each set and checks the result transfers.
  class mode_scoreboard;
    int unsigned   bin_count[TB_BINS];
    int unsigned   best_value;
    int unsigned   best_count;
    hmf_pkg::out_t expected_modes[$];
    int            mismatch_count;

    function new();
      mismatch_count = 0;
      clear_set();
    endfunction

    function void clear_set();
      foreach (bin_count[i]) bin_count[i] = 0;
      best_value = 0;
      best_count = 0;
    endfunction

    // Counts one accepted sample and queues the result when the set ends.
    function void note_sample(hmf_pkg::in_t s);
      int unsigned   v;
      int unsigned   c;
      hmf_pkg::out_t res;
      v = s.sample_value;
      if (v < TB_BINS) begin
        c = bin_count[v];
        if (c < TB_MAX_ITEMS) c++;
        bin_count[v] = c;
        if (c > best_count) begin
          best_count = c;
          best_value = v;
        end
      end
      if (s.last_item) begin
        res = '0;
        if (best_count > 1) begin
          res.repeat_found = 1'b1;
          res.mode_value   = best_value[hmf_pkg::VAL_W-1:0];
          res.mode_count   = best_count[hmf_pkg::MCNT_W-1:0];
        end
        expected_modes.push_back(res);
        clear_set();
      end
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_result(hmf_pkg::out_t got);
      hmf_pkg::out_t want;
      if (expected_modes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result rep=%0d val=%0d cnt=%0d", $time,
                 got.repeat_found, got.mode_value, got.mode_count);
        return;
      end
      want = expected_modes.pop_front();
      if (got.repeat_found !== want.repeat_found ||
          got.mode_value !== want.mode_value ||
          got.mode_count !== want.mode_count) begin
        mismatch_count++;
        $display({"%0t: mode mismatch, expected rep=%0d val=%0d cnt=%0d, ",
                  "got rep=%0d val=%0d cnt=%0d"},
                 $time, want.repeat_found, want.mode_value, want.mode_count,
                 got.repeat_found, got.mode_value, got.mode_count);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  hmf_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready = 1'b0;
  hmf_pkg::out_t out_data;

  mode_scoreboard sb = new();
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned samples_sent = 0;
  int unsigned quiet_cycles = 0;

  histogram_mode_finder #(
    .BINS      (TB_BINS),
    .MAX_ITEMS (TB_MAX_ITEMS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: checks each result transfer and stalls at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Idling rates of each phase: none, sender, receiver, both.
  task automatic set_phase(input int phase);
    case (phase)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 79; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 79; end
      default: begin idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  // Drives one sample and waits for its transfer.
  task automatic send_sample(input hmf_pkg::in_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
    samples_sent++;
  endtask

  // Sends a whole set; the last value carries the end flag.
  task automatic send_set(input int unsigned vals[$]);
    hmf_pkg::in_t s;
    foreach (vals[i]) begin
      s.sample_value = vals[i][hmf_pkg::VAL_W-1:0];
      s.last_item    = (i == vals.size() - 1);
      send_sample(s);
    end
  endtask

  // Directed sets: range ends, ties, no repeats, value zero repeated.
  task automatic run_directed();
    send_set('{0});
    send_set('{1023});
    send_set('{1023, 1023});
    send_set('{5, 7, 5, 7});
    send_set('{3, 9, 9, 3, 3});
    send_set('{0, 512, 1023, 341, 682});
    send_set('{0, 0});
  endtask

  // Random sets spread over the four idling phases.
  task automatic run_random();
    int unsigned vals[$];
    int unsigned pool[8];
    int unsigned start;
    int unsigned kind;
    int unsigned len;
    int unsigned npool;
    int unsigned va;
    int unsigned vb;
    int          phase;
    start = samples_sent;

    // One set where two values both saturate; the first keeps the mode.
    va = $urandom_range(TB_BINS - 1);
    vb = (va + $urandom_range(1, TB_BINS - 1)) % TB_BINS;
    for (int i = 0; i < TB_MAX_ITEMS + 2; i++) vals.push_back(va);
    for (int i = 0; i < TB_MAX_ITEMS + 2; i++) vals.push_back(vb);
    send_set(vals);

    while (samples_sent - start < RANDOM_SAMPLES) begin
      phase = (samples_sent - start) * 4 / RANDOM_SAMPLES;
      set_phase(phase);
      vals.delete();
      foreach (pool[i]) pool[i] = $urandom_range(TB_BINS - 1);
      kind = $urandom_range(99);
      if (kind < 70) begin
        // Short set from a small pool, so repeats and ties are common.
        len   = $urandom_range(1, 16);
        npool = $urandom_range(1, 4);
      end else if (kind < 85) begin
        // Noise: values over the whole range.
        len   = $urandom_range(1, 12);
        npool = 8;
        for (int i = 0; i < len; i++) pool[i % 8] = $urandom_range(TB_BINS - 1);
      end else if (kind < 96) begin
        // Longer set with deeper counts.
        len   = $urandom_range(17, 60);
        npool = $urandom_range(2, 8);
      end else begin
        // Long set that pushes a bin to saturation.
        len   = TB_MAX_ITEMS + $urandom_range(2, 40);
        npool = 2;
        pool[1] = pool[0];
      end
      for (int i = 0; i < len; i++) begin
        if (kind >= 70 && kind < 85) vals.push_back($urandom_range(TB_BINS - 1));
        else vals.push_back(pool[$urandom_range(npool - 1)]);
      end
      send_set(vals);
    end
  endtask

  // Reset, stimulus, drain and final verdict.
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_phase(0);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.expected_modes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_modes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> histogram_mode_finder.f
hdl/hmf_pkg.sv
hdl/hmf_ram.sv
hdl/histogram_mode_finder.sv
bench/histogram_mode_finder_test.sv
